// ===== hdl/cstrip_pkg.sv =====
// Shared types and constants for the comment stripper.
package cstrip_pkg;

    localparam int CH_BITS   = 21;
    localparam int LINE_BITS = 20;
    localparam int COL_BITS  = 16;
    localparam int MAX_RES   = 3;

    // Character codes the scanner reacts to.
    localparam logic [CH_BITS-1:0] C_SLASH = CH_BITS'(8'h2F);
    localparam logic [CH_BITS-1:0] C_STAR  = CH_BITS'(8'h2A);
    localparam logic [CH_BITS-1:0] C_NL    = CH_BITS'(8'h0A);
    localparam logic [CH_BITS-1:0] C_DQ    = CH_BITS'(8'h22);
    localparam logic [CH_BITS-1:0] C_SQ    = CH_BITS'(8'h27);
    localparam logic [CH_BITS-1:0] C_BSL   = CH_BITS'(8'h5C);
    localparam logic [CH_BITS-1:0] C_SP    = CH_BITS'(8'h20);

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_SLASH  = 3'd1,
        M_LINE   = 3'd2,
        M_BLOCK  = 3'd3,
        M_BSTAR  = 3'd4,
        M_STR    = 3'd5,
        M_CHR    = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_BLOCK = 2'd1,
        ERR_STR   = 2'd2,
        ERR_CHR   = 2'd3
    } err_t;

    // Scanner state carried from one character to the next.
    typedef struct packed {
        mode_t                mode;
        logic                 prev_bsl;
        logic [LINE_BITS-1:0] held_line;
        logic [COL_BITS-1:0]  held_col;
        logic [LINE_BITS-1:0] opener_line;
        logic [COL_BITS-1:0]  opener_col;
    } scan_state_t;

    // One result item.
    typedef struct packed {
        logic [CH_BITS-1:0]   ch;
        logic [LINE_BITS-1:0] line;
        logic [COL_BITS-1:0]  col;
        err_t                 err;
        logic                 last;
    } result_t;

    localparam scan_state_t SCAN_RESET = '{
        mode: M_NORMAL, prev_bsl: 1'b0,
        held_line: '0, held_col: '0, opener_line: '0, opener_col: '0
    };

endpackage

// ===== hdl/cstrip_step.sv =====
// Per-character scanner: next state and up to three result items.
module cstrip_step
    import cstrip_pkg::*;
(
    input  scan_state_t          st,
    input  logic [CH_BITS-1:0]   ch,
    input  logic [LINE_BITS-1:0] line_no,
    input  logic [COL_BITS-1:0]  col_no,
    input  logic                 last,
    output scan_state_t          st_next,
    output result_t              res [MAX_RES],
    output logic [1:0]           res_cnt
);

    always_comb begin
        logic       do_normal;
        logic [1:0] n;
        result_t    r;

        st_next   = st;
        do_normal = 1'b0;
        n         = 2'd0;
        r         = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            res[i] = '0;
        end

        // Mode-specific handling of the incoming character.
        unique case (st.mode)
            M_SLASH: begin
                if (ch == C_SLASH) begin
                    r = '{ch: C_SP, line: '0, col: '0, err: ERR_NONE, last: 1'b0};
                    res[n] = r;
                    n = n + 2'd1;
                    st_next.mode = M_LINE;
                end else if (ch == C_STAR) begin
                    r = '{ch: C_SP, line: '0, col: '0, err: ERR_NONE, last: 1'b0};
                    res[n] = r;
                    n = n + 2'd1;
                    st_next.opener_line = st.held_line;
                    st_next.opener_col  = st.held_col;
                    st_next.mode        = M_BLOCK;
                end else begin
                    r = '{ch: C_SLASH, line: st.held_line, col: st.held_col,
                          err: ERR_NONE, last: 1'b0};
                    res[n] = r;
                    n = n + 2'd1;
                    do_normal = 1'b1;
                end
            end
            M_LINE: begin
                if (ch == C_NL) begin
                    do_normal = 1'b1;
                end
            end
            M_BLOCK: begin
                if (ch == C_STAR) begin
                    st_next.mode = M_BSTAR;
                end
            end
            M_BSTAR: begin
                if (ch == C_SLASH) begin
                    st_next.mode = M_NORMAL;
                end else if (ch != C_STAR) begin
                    st_next.mode = M_BLOCK;
                end
            end
            M_STR, M_CHR: begin
                r = '{ch: ch, line: line_no, col: col_no, err: ERR_NONE, last: 1'b0};
                res[n] = r;
                n = n + 2'd1;
                if (!st.prev_bsl && (ch == ((st.mode == M_STR) ? C_DQ : C_SQ))) begin
                    st_next.mode = M_NORMAL;
                end
                st_next.prev_bsl = (ch == C_BSL);
            end
            default: begin
                do_normal = 1'b1;
            end
        endcase

        // Ordinary text: hold a slash, pass anything else, note literal openers.
        if (do_normal) begin
            st_next.mode = M_NORMAL;
            if (ch == C_SLASH) begin
                st_next.held_line = line_no;
                st_next.held_col  = col_no;
                st_next.mode      = M_SLASH;
            end else begin
                r = '{ch: ch, line: line_no, col: col_no, err: ERR_NONE, last: 1'b0};
                if (n != 2'd3) begin
                    res[n] = r;
                end
                n = n + 2'd1;
                if (ch == C_DQ || ch == C_SQ) begin
                    st_next.opener_line = line_no;
                    st_next.opener_col  = col_no;
                    st_next.prev_bsl    = 1'b0;
                    st_next.mode        = (ch == C_DQ) ? M_STR : M_CHR;
                end
            end
        end

        // End of stream: flush a held slash or report an open construct.
        if (last) begin
            r = '0;
            unique case (st_next.mode)
                M_SLASH: begin
                    r = '{ch: C_SLASH, line: st_next.held_line, col: st_next.held_col,
                          err: ERR_NONE, last: 1'b0};
                end
                M_BLOCK, M_BSTAR: begin
                    r = '{ch: '0, line: st_next.opener_line, col: st_next.opener_col,
                          err: ERR_BLOCK, last: 1'b0};
                end
                M_STR: begin
                    r = '{ch: '0, line: st_next.opener_line, col: st_next.opener_col,
                          err: ERR_STR, last: 1'b0};
                end
                M_CHR: begin
                    r = '{ch: '0, line: st_next.opener_line, col: st_next.opener_col,
                          err: ERR_CHR, last: 1'b0};
                end
                default: begin
                    r = '0;
                end
            endcase
            if (st_next.mode != M_NORMAL && st_next.mode != M_LINE) begin
                if (n != 2'd3) begin
                    res[n] = r;
                end
                n = n + 2'd1;
            end
            // An empty end still produces one end mark.
            if (n == 2'd0) begin
                res[0] = '0;
                n = 2'd1;
            end
            res[2'(n - 2'd1)].last = 1'b1;
            st_next = SCAN_RESET;
        end

        res_cnt = n;
    end

endmodule

// ===== hdl/comment_stripper.sv =====
// Top level of the comment stripper: input handshake, scanner state, result buffer.
//
// Usage: characters arrive on the s_ channel, one transfer per character, each
// with its line, column and a last flag for the end of the source. Stripped
// text leaves on the m_ channel with error and out_last tags. A comment is
// replaced by one space at line 0, column 0; an unclosed block comment or
// literal at end of stream gives an error item at the opener's position.
// A character's results are registered and appear in the cycle after its transfer.
// Throughput: each character yields 0 to 3 results and the result buffer
// drains one per cycle while the receiver is ready, so plain text then runs
// at one character per cycle. A new character is taken in the
// same cycle that the last buffered result is transferred.
// Reset (aresetn low, synchronous) returns the scanner to normal text and
// empties the buffer. When the receiver stalls, the buffered results hold
// and s_ready stays low until the last of them is transferred.
module comment_stripper
    import cstrip_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CH_BITS-1:0]   s_ch,
    input  logic [LINE_BITS-1:0] s_line_no,
    input  logic [COL_BITS-1:0]  s_col_no,
    input  logic                 s_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CH_BITS-1:0]   m_out_ch,
    output logic [LINE_BITS-1:0] m_out_line,
    output logic [COL_BITS-1:0]  m_out_col,
    output logic [1:0]           m_error,
    output logic                 m_out_last
);

    scan_state_t state_reg;
    scan_state_t state_next;
    result_t     step_res [MAX_RES];
    logic [1:0]  step_cnt;
    result_t     res_reg  [MAX_RES];
    logic [1:0]  cnt_reg;
    logic [1:0]  idx_reg;
    logic        s_xfer;
    logic        m_xfer;
    logic        drain_done;
    result_t     cur;

    cstrip_step u_step (
        .st      (state_reg),
        .ch      (s_ch),
        .line_no (s_line_no),
        .col_no  (s_col_no),
        .last    (s_last),
        .st_next (state_next),
        .res     (step_res),
        .res_cnt (step_cnt)
    );

    // Handshake: a character enters when the buffer is empty or empties this cycle.
    assign m_valid    = (cnt_reg != 2'd0);
    assign m_xfer     = m_valid && m_ready;
    assign drain_done = m_xfer && (idx_reg == 2'(cnt_reg - 2'd1));
    assign s_ready    = !m_valid || drain_done;
    assign s_xfer     = s_valid && s_ready;

    // Scanner state advances on each input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_RESET;
        end else if (s_xfer) begin
            state_reg <= state_next;
        end
    end

    // Result buffer control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (s_xfer) begin
            cnt_reg <= step_cnt;
            idx_reg <= 2'd0;
        end else if (drain_done) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (m_xfer) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Result buffer payload.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            for (int i = 0; i < MAX_RES; i++) begin
                res_reg[i] <= step_res[i];
            end
        end
    end

    // Present the current buffered result.
    assign cur        = res_reg[idx_reg];
    assign m_out_ch   = cur.ch;
    assign m_out_line = cur.line;
    assign m_out_col  = cur.col;
    assign m_error    = cur.err;
    assign m_out_last = cur.last;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for comment_stripper: directed and random character streams.
module testbench
    import cstrip_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 350;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [CH_BITS-1:0] C_LOWER_A = CH_BITS'(8'h61);
    localparam logic [CH_BITS-1:0] C_LOWER_Z = CH_BITS'(8'h7A);

    // One source character as offered on the input channel.
    typedef struct {
        logic [CH_BITS-1:0]   ch;
        logic [LINE_BITS-1:0] line;
        logic [COL_BITS-1:0]  col;
        logic                 last;
    } src_char_t;

    // Predicts the stripped stream and checks each result transfer against it.
    class strip_checker;
        result_t     expected_q[$];
        scan_state_t scan;
        result_t     step_res[MAX_RES];
        int          n_step;
        int          n_errors;
        int          n_chars;
        int          n_streams;
        int          n_results;
        int          n_err_items;

        function new();
            scan = SCAN_RESET;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Adds one result for the character being processed.
        function void emit(logic [CH_BITS-1:0] c, logic [LINE_BITS-1:0] ln,
                           logic [COL_BITS-1:0] cl, err_t err);
            if (n_step < MAX_RES) begin
                step_res[n_step].ch   = c;
                step_res[n_step].line = ln;
                step_res[n_step].col  = cl;
                step_res[n_step].err  = err;
                step_res[n_step].last = 1'b0;
                n_step++;
            end
        endfunction

        // A character seen as plain text: may hold a slash or open a literal.
        function void take_text(logic [CH_BITS-1:0] c, logic [LINE_BITS-1:0] ln,
                                logic [COL_BITS-1:0] cl);
            scan.mode = M_NORMAL;
            if (c == C_SLASH) begin
                scan.held_line = ln;
                scan.held_col  = cl;
                scan.mode      = M_SLASH;
            end else begin
                emit(c, ln, cl, ERR_NONE);
                if (c == C_DQ || c == C_SQ) begin
                    scan.opener_line = ln;
                    scan.opener_col  = cl;
                    scan.prev_bsl    = 1'b0;
                    if (c == C_DQ)
                        scan.mode = M_STR;
                    else
                        scan.mode = M_CHR;
                end
            end
        endfunction

        // Notes an accepted input transfer and queues the results it causes.
        function void note_char(logic [CH_BITS-1:0] c, logic [LINE_BITS-1:0] ln,
                                logic [COL_BITS-1:0] cl, logic is_last);
            logic [CH_BITS-1:0] quote;
            n_step = 0;
            case (scan.mode)
                M_SLASH: begin
                    if (c == C_SLASH) begin
                        emit(C_SP, '0, '0, ERR_NONE);
                        scan.mode = M_LINE;
                    end else if (c == C_STAR) begin
                        emit(C_SP, '0, '0, ERR_NONE);
                        scan.opener_line = scan.held_line;
                        scan.opener_col  = scan.held_col;
                        scan.mode        = M_BLOCK;
                    end else begin
                        emit(C_SLASH, scan.held_line, scan.held_col, ERR_NONE);
                        take_text(c, ln, cl);
                    end
                end
                M_LINE: begin
                    if (c == C_NL)
                        take_text(c, ln, cl);
                end
                M_BLOCK: begin
                    if (c == C_STAR)
                        scan.mode = M_BSTAR;
                end
                M_BSTAR: begin
                    if (c == C_SLASH)
                        scan.mode = M_NORMAL;
                    else if (c != C_STAR)
                        scan.mode = M_BLOCK;
                end
                M_STR, M_CHR: begin
                    quote = (scan.mode == M_STR) ? C_DQ : C_SQ;
                    emit(c, ln, cl, ERR_NONE);
                    if (!scan.prev_bsl && c == quote)
                        scan.mode = M_NORMAL;
                    scan.prev_bsl = (c == C_BSL);
                end
                default: take_text(c, ln, cl);
            endcase

            // End of stream: flush a held slash or report an open construct.
            if (is_last) begin
                case (scan.mode)
                    M_SLASH: emit(C_SLASH, scan.held_line, scan.held_col, ERR_NONE);
                    M_BLOCK, M_BSTAR: emit('0, scan.opener_line, scan.opener_col, ERR_BLOCK);
                    M_STR: emit('0, scan.opener_line, scan.opener_col, ERR_STR);
                    M_CHR: emit('0, scan.opener_line, scan.opener_col, ERR_CHR);
                    default: ;
                endcase
                if (n_step == 0)
                    emit('0, '0, '0, ERR_NONE);
                step_res[n_step-1].last = 1'b1;
                scan = SCAN_RESET;
                n_streams++;
            end
            for (int i = 0; i < n_step; i++)
                expected_q.insert(expected_q.size(), step_res[i]);
            n_chars++;
        endfunction

        // Compares one result transfer with the oldest expected result.
        function void check_result(result_t got);
            result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("Result transfer with nothing expected: out_ch %0h", got.ch);
                n_errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            n_results++;
            if (exp_r.err != ERR_NONE)
                n_err_items++;
            if (got.ch !== exp_r.ch) begin
                $error("out_ch: expected %0h, got %0h", exp_r.ch, got.ch);
                n_errors++;
            end
            if (got.line !== exp_r.line) begin
                $error("out_line: expected %0d, got %0d", exp_r.line, got.line);
                n_errors++;
            end
            if (got.col !== exp_r.col) begin
                $error("out_col: expected %0d, got %0d", exp_r.col, got.col);
                n_errors++;
            end
            if (got.err !== exp_r.err) begin
                $error("error: expected %0d, got %0d", exp_r.err, got.err);
                n_errors++;
            end
            if (got.last !== exp_r.last) begin
                $error("out_last: expected %0b, got %0b", exp_r.last, got.last);
                n_errors++;
            end
        endfunction
    endclass

    logic                 aclk       = 1'b0;
    logic                 aresetn    = 1'b0;
    logic                 s_valid    = 1'b0;
    logic                 s_ready;
    logic [CH_BITS-1:0]   s_ch       = '0;
    logic [LINE_BITS-1:0] s_line_no  = '0;
    logic [COL_BITS-1:0]  s_col_no   = '0;
    logic                 s_last     = 1'b0;
    logic                 m_valid;
    logic                 m_ready    = 1'b0;
    logic [CH_BITS-1:0]   m_out_ch;
    logic [LINE_BITS-1:0] m_out_line;
    logic [COL_BITS-1:0]  m_out_col;
    logic [1:0]           m_error;
    logic                 m_out_last;

    strip_checker         sb;
    src_char_t            stim_q[$];
    logic [LINE_BITS-1:0] cur_line;
    logic [COL_BITS-1:0]  cur_col;
    logic                 no_gaps  = 1'b0;
    logic                 hold_req = 1'b0;
    int                   idle_cycles = 0;

    comment_stripper dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_ch       (s_ch),
        .s_line_no  (s_line_no),
        .s_col_no   (s_col_no),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_ch   (m_out_ch),
        .m_out_line (m_out_line),
        .m_out_col  (m_out_col),
        .m_error    (m_error),
        .m_out_last (m_out_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Gap lengths: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Appends a character at the current position and advances the position.
    function automatic void push_char(logic [CH_BITS-1:0] c, logic is_last);
        src_char_t item;
        item.ch   = c;
        item.line = cur_line;
        item.col  = cur_col;
        item.last = is_last;
        stim_q.insert(stim_q.size(), item);
        if (c == C_NL) begin
            cur_line = cur_line + LINE_BITS'(1);
            cur_col  = COL_BITS'(1);
        end else begin
            cur_col = cur_col + COL_BITS'(1);
        end
    endfunction

    function automatic logic [CH_BITS-1:0] special_char();
        case ($urandom_range(0, 6))
            0: return C_SLASH;
            1: return C_STAR;
            2: return C_NL;
            3: return C_DQ;
            4: return C_SQ;
            5: return C_BSL;
            default: return C_SP;
        endcase
    endfunction

    // Mostly plain text: letters, random code points, newlines, blanks.
    function automatic logic [CH_BITS-1:0] plain_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return CH_BITS'($urandom_range(C_LOWER_A, C_LOWER_Z));
            5: return CH_BITS'($urandom);
            6: return CH_BITS'($urandom_range(0, 16'hFFFF));
            7: return C_NL;
            default: return C_SP;
        endcase
    endfunction

    function automatic logic [CH_BITS-1:0] any_char();
        if ($urandom_range(0, 3) == 0)
            return special_char();
        return plain_char();
    endfunction

    // A quoted literal with random body and backslash escapes.
    function automatic void push_quoted(logic [CH_BITS-1:0] q, int max_len);
        logic [CH_BITS-1:0] c;
        push_char(q, 1'b0);
        repeat ($urandom_range(0, max_len)) begin
            if ($urandom_range(0, 4) == 0) begin
                push_char(C_BSL, 1'b0);
                push_char(any_char(), 1'b0);
            end else begin
                c = any_char();
                if (c == q || c == C_BSL)
                    c = C_LOWER_A;
                push_char(c, 1'b0);
            end
        end
        push_char(q, 1'b0);
    endfunction

    // One random stream: comments, literals, plain text and special characters,
    // then an ending that may leave a construct open.
    function automatic void build_stream();
        logic [CH_BITS-1:0] c;
        logic               prev_star;
        cur_line = LINE_BITS'($urandom);
        cur_col  = COL_BITS'($urandom);
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 6)) push_char(plain_char(), 1'b0);
                3, 4: begin
                    push_char(C_SLASH, 1'b0);
                    push_char(C_SLASH, 1'b0);
                    repeat ($urandom_range(0, 6)) begin
                        c = any_char();
                        if (c == C_NL)
                            c = C_SP;
                        push_char(c, 1'b0);
                    end
                    push_char(C_NL, 1'b0);
                end
                5, 6: begin
                    push_char(C_SLASH, 1'b0);
                    push_char(C_STAR, 1'b0);
                    prev_star = 1'b0;
                    repeat ($urandom_range(0, 8)) begin
                        c = ($urandom_range(0, 3) == 0) ? C_STAR : any_char();
                        if (prev_star && c == C_SLASH)
                            c = C_SP;
                        push_char(c, 1'b0);
                        prev_star = (c == C_STAR);
                    end
                    push_char(C_STAR, 1'b0);
                    push_char(C_SLASH, 1'b0);
                end
                7: push_quoted(C_DQ, 6);
                8: push_quoted(C_SQ, 2);
                default: repeat ($urandom_range(1, 4)) push_char(special_char(), 1'b0);
            endcase
        end
        case ($urandom_range(0, 7))
            0: push_char(C_SLASH, 1'b1);
            1: begin
                push_char(C_SLASH, 1'b0);
                push_char(C_STAR, 1'b1);
            end
            2: begin
                push_char(C_SLASH, 1'b0);
                push_char(C_STAR, 1'b0);
                push_char(any_char(), 1'b1);
            end
            3: begin
                push_char(C_DQ, 1'b0);
                push_char(any_char(), 1'b1);
            end
            4: push_char(C_SQ, 1'b1);
            5: begin
                push_char(C_SLASH, 1'b0);
                push_char(C_SLASH, 1'b0);
                push_char(any_char(), 1'b1);
            end
            default: push_char(any_char(), 1'b1);
        endcase
    endfunction

    // Offers one character after a random gap and waits for its transfer.
    task automatic send_char(src_char_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_ch      <= item.ch;
        s_line_no <= item.line;
        s_col_no  <= item.col;
        s_last    <= item.last;
        do @(posedge aclk); while (!s_ready);
        sb.note_char(item.ch, item.line, item.col, item.last);
    endtask

    // Result side: checks each transfer, then picks the next ready value.
    initial begin : result_side
        result_t got;
        int      rx_stall;
        rx_stall = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.ch   = m_out_ch;
                got.line = m_out_line;
                got.col  = m_out_col;
                got.err  = err_t'(m_error);
                got.last = m_out_last;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                rx_stall = HOLD_CYCLES;
            end else if (rx_stall == 0) begin
                rx_stall = pick_gap();
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, sb.pending());
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int directed_n;
        sb = new();

        // Extremes of the character, line and column fields.
        cur_line = '1;
        cur_col  = '1;
        push_char('1, 1'b0);
        cur_line = '0;
        cur_col  = '0;
        push_char('0, 1'b0);
        // Line comment ending before its newline.
        push_char(C_SLASH, 1'b0);
        push_char(C_SLASH, 1'b0);
        push_char(C_LOWER_Z, 1'b0);
        push_char(C_NL, 1'b0);
        // Block comment with a star run and a stray star; the stream ends on
        // the closing slash, so nothing is emitted and an end mark follows.
        push_char(C_SLASH, 1'b0);
        push_char(C_STAR, 1'b0);
        push_char(C_STAR, 1'b0);
        push_char(C_LOWER_A, 1'b0);
        push_char(C_STAR, 1'b0);
        push_char(C_SLASH, 1'b1);
        // String with an escaped quote.
        push_char(C_DQ, 1'b0);
        push_char(C_BSL, 1'b0);
        push_char(C_DQ, 1'b0);
        push_char(C_DQ, 1'b0);
        // Character literal.
        push_char(C_SQ, 1'b0);
        push_char(C_LOWER_A, 1'b0);
        push_char(C_SQ, 1'b0);
        // Held slash released by a quote that stays open at the end.
        push_char(C_SLASH, 1'b0);
        push_char(C_DQ, 1'b1);
        // Slash as the last character.
        push_char(C_SLASH, 1'b1);
        // Block opener as the last two characters.
        push_char(C_SLASH, 1'b0);
        push_char(C_STAR, 1'b1);
        // Unclosed character literal.
        push_char(C_SQ, 1'b1);
        directed_n = stim_q.size();

        while (stim_q.size() < directed_n + RANDOM_ITEMS)
            build_stream();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Drive every character; one window runs without gaps, one point
        // stalls the receiver for long, one point drains the block fully.
        for (int i = 0; i < stim_q.size(); i++) begin
            no_gaps = (i >= directed_n + 60 && i < directed_n + 110);
            if (i == directed_n + 150)
                hold_req = 1'b1;
            if (i == directed_n + 250) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (sb.pending() != 0);
            end
            send_char(stim_q[i]);
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d characters in %0d streams; checked %0d results, %0d error items.",
                 sb.n_chars, sb.n_streams, sb.n_results, sb.n_err_items);
        $display("Covered comments, literals, escapes, held slashes, open constructs and stalls.");
        if (sb.n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/cstrip_pkg.sv
hdl/cstrip_step.sv
hdl/comment_stripper.sv
sim/testbench.sv
